[rtl/core/pnp_resource_descriptor_parser_core_macros.svh]
// Assertion macros for the resource descriptor parser core.
// Included by the top level; uses the including module's i_clk and i_rst_n.
`ifndef PNP_RESOURCE_DESCRIPTOR_PARSER_CORE_MACROS_SVH
`define PNP_RESOURCE_DESCRIPTOR_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define PNP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pnp parser check failed");

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define PNP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pnp parser check failed");

`endif

[rtl/core/pnp_rdp_pkg.sv]
// Shared types, codes and helpers for the resource descriptor parser.
// No dependencies; used by pnp_rdp_decode and the core top level.
package pnp_rdp_pkg;

    localparam int DEF_CAPTURE_BYTES = 20;
    localparam int IDX_W             = 17;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_kind;

    // Resource record kinds
    localparam t_kind KIND_MEM = 2'd0;
    localparam t_kind KIND_IO  = 2'd1;
    localparam t_kind KIND_IRQ = 2'd2;
    localparam t_kind KIND_DMA = 2'd3;

    // Large item types (tag bits 6:0)
    localparam logic [6:0] LTYPE_MEM24    = 7'h01;
    localparam logic [6:0] LTYPE_MEM32    = 7'h05;
    localparam logic [6:0] LTYPE_FIXMEM32 = 7'h06;

    // Small item types (tag bits 6:3)
    localparam logic [3:0] STYPE_IRQ   = 4'h4;
    localparam logic [3:0] STYPE_DMA   = 4'h5;
    localparam logic [3:0] STYPE_IO    = 4'h8;
    localparam logic [3:0] STYPE_FIXIO = 4'h9;
    localparam logic [3:0] STYPE_END   = 4'hF;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] length;
    } t_record;

    typedef struct packed {
        logic       found;
        logic [3:0] pos;
    } t_top_bit;

    // Highest set bit of a 16-bit mask
    function automatic t_top_bit top_bit16(input logic [15:0] mask);
        t_top_bit res;
        res = '0;
        for (int i = 0; i < 16; i++) begin
            if (mask[i]) begin
                res.found = 1'b1;
                res.pos   = 4'(i);
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/pnp_resource_descriptor_parser_core.sv]
// Plug and Play resource data parser, top level. Uses pnp_rdp_pkg and
// pnp_rdp_decode; assertions come from the core macros header.
//
// Input channel: one resource data byte per beat (i_valid/o_ready) with
// i_node_start flagging the first byte of a node and i_node_last the last.
// Output channel: one resource record per beat (o_valid/i_ready): kind,
// start and length. Bytes that finish no record produce no output beat.
// A record is registered from the byte that closes its item. Throughput:
// one byte per cycle unless stalled; tag decode, the capture write and
// the record decode all sit between the parser state and output register.
// Stall: while a record waits in the output register and i_ready is low,
// o_ready drops; with i_ready high a new byte is taken in the same cycle
// the pending record leaves.
// Reset: parser expects a tag, output register is empty.
`include "pnp_resource_descriptor_parser_core_macros.svh"

module pnp_resource_descriptor_parser_core
    import pnp_rdp_pkg::*;
#(
    parameter int CAPTURE_BYTES = DEF_CAPTURE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_node_start,
    input  logic        i_node_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_resource_kind,
    output logic [31:0] o_range_start,
    output logic [31:0] o_range_length
);

    localparam int CAP_W = $clog2(CAPTURE_BYTES);

    // Parser modes
    localparam logic [1:0] MODE_TAG  = 2'd0;
    localparam logic [1:0] MODE_ITEM = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    logic [1:0]                     r_mode, n_mode;
    t_byte                          r_tag, n_tag;
    logic [IDX_W-1:0]               r_total, n_total;
    logic [IDX_W-1:0]               r_idx, n_idx;
    logic [CAPTURE_BYTES-1:0][7:0]  r_cap, n_cap;
    logic                           r_out_valid;
    t_record                        r_out;

    logic       accept;
    logic [1:0] mode_cur;
    logic       done, zero_len, closeable, close_item;
    logic       dec_valid;
    t_record    dec_rec;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Next parser state for the byte at the input
    always_comb begin
        n_mode    = r_mode;
        n_tag     = r_tag;
        n_total   = r_total;
        n_idx     = r_idx;
        n_cap     = r_cap;
        done      = 1'b0;
        zero_len  = 1'b0;
        closeable = 1'b0;
        mode_cur  = i_node_start ? MODE_TAG : r_mode;
        unique case (mode_cur)
            MODE_TAG: begin
                n_cap    = '0;
                n_cap[0] = i_data_byte;
                n_tag    = i_data_byte;
                n_idx    = IDX_W'(1);
                if (i_data_byte[7]) begin
                    n_total   = '0;
                    n_mode    = MODE_ITEM;
                    closeable = 1'b1;
                end else if (i_data_byte[6:3] == STYPE_END) begin
                    n_mode = MODE_STOP;
                end else begin
                    n_total   = IDX_W'(1) + IDX_W'(i_data_byte[2:0]);
                    n_mode    = MODE_ITEM;
                    closeable = 1'b1;
                    if (i_data_byte[2:0] == 3'd0) begin
                        done     = 1'b1;
                        zero_len = 1'b1;
                    end
                end
            end
            MODE_ITEM: begin
                closeable = 1'b1;
                if (r_idx < IDX_W'(CAPTURE_BYTES)) begin
                    n_cap[r_idx[CAP_W-1:0]] = i_data_byte;
                end
                n_idx = r_idx + IDX_W'(1);
                // Large item: length known once the header is in
                if (r_tag[7] && n_idx == IDX_W'(3)) begin
                    n_total = IDX_W'(3) + IDX_W'({n_cap[2], n_cap[1]});
                    if ({n_cap[2], n_cap[1]} == 16'h0000) begin
                        zero_len = 1'b1;
                    end
                end
                if ((n_idx >= IDX_W'(3) || !r_tag[7]) && n_idx == n_total) begin
                    done = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_STOP;
            end
        endcase
        close_item = closeable && (done || i_node_last);
        if (close_item) begin
            n_mode = (i_node_last || zero_len) ? MODE_STOP : MODE_TAG;
        end
    end

    pnp_rdp_decode #(
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_decode (
        .i_tag       (n_tag),
        .i_cap       (n_cap),
        .o_rec_valid (dec_valid),
        .o_rec       (dec_rec)
    );

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TAG;
            r_tag   <= '0;
            r_total <= '0;
            r_idx   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_tag   <= n_tag;
            r_total <= n_total;
            r_idx   <= n_idx;
        end
    end

    // Capture bytes; every new tag clears them
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cap <= n_cap;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= close_item && dec_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && close_item && dec_valid) begin
            r_out <= dec_rec;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_resource_kind = r_out.kind;
    assign o_range_start   = r_out.start;
    assign o_range_length  = r_out.length;

    // Checks
    `PNP_ASSERT_NOW(a_stall_blocks_input, o_valid && !i_ready, !o_ready)
    `PNP_ASSERT_NEXT(a_stopped_no_record,
        accept && r_mode == MODE_STOP && !i_node_start, !o_valid)
    `PNP_ASSERT_NOW(a_irq_dma_shape,
        o_valid && (o_resource_kind == KIND_IRQ || o_resource_kind == KIND_DMA),
        o_range_length == 32'd1 && o_range_start < 32'd16)
    `PNP_ASSERT_NEXT(a_end_tag_silent,
        accept && (i_node_start || r_mode == MODE_TAG) && !i_data_byte[7]
            && i_data_byte[6:3] == STYPE_END, !o_valid)

endmodule

[rtl/core/pnp_rdp_decode.sv]
// Item decoder: turns a finished item's tag and captured bytes into a record.
// Depends on pnp_rdp_pkg.
module pnp_rdp_decode
    import pnp_rdp_pkg::*;
#(
    parameter int CAPTURE_BYTES = DEF_CAPTURE_BYTES
) (
    input  t_byte                          i_tag,
    input  logic [CAPTURE_BYTES-1:0][7:0]  i_cap,
    output logic                           o_rec_valid,
    output t_record                        o_rec
);

    logic [15:0] w16_at1, w16_at2, w16_at4, w16_at10;
    logic [31:0] w32_at4, w32_at8, w32_at16;
    t_top_bit    irq_bit, dma_bit;

    // Little-endian fields at fixed offsets
    assign w16_at1  = {i_cap[2],  i_cap[1]};
    assign w16_at2  = {i_cap[3],  i_cap[2]};
    assign w16_at4  = {i_cap[5],  i_cap[4]};
    assign w16_at10 = {i_cap[11], i_cap[10]};
    assign w32_at4  = {i_cap[7],  i_cap[6],  i_cap[5],  i_cap[4]};
    assign w32_at8  = {i_cap[11], i_cap[10], i_cap[9],  i_cap[8]};
    assign w32_at16 = {i_cap[19], i_cap[18], i_cap[17], i_cap[16]};

    assign irq_bit = top_bit16(w16_at1);
    assign dma_bit = top_bit16({8'h00, i_cap[1]});

    // Record select by item type
    always_comb begin
        o_rec_valid = 1'b0;
        o_rec       = '0;
        if (i_tag[7]) begin
            unique case (i_tag[6:0])
                LTYPE_MEM24: begin
                    o_rec_valid  = 1'b1;
                    o_rec.kind   = KIND_MEM;
                    o_rec.start  = {8'h00, w16_at4, 8'h00};
                    o_rec.length = {8'h00, w16_at10, 8'h00};
                end
                LTYPE_MEM32: begin
                    o_rec_valid  = 1'b1;
                    o_rec.kind   = KIND_MEM;
                    o_rec.start  = w32_at4;
                    o_rec.length = w32_at16;
                end
                LTYPE_FIXMEM32: begin
                    o_rec_valid  = 1'b1;
                    o_rec.kind   = KIND_MEM;
                    o_rec.start  = w32_at4;
                    o_rec.length = w32_at8;
                end
                default: ;
            endcase
        end else begin
            unique case (i_tag[6:3])
                STYPE_IRQ: begin
                    o_rec_valid  = irq_bit.found;
                    o_rec.kind   = KIND_IRQ;
                    o_rec.start  = 32'(irq_bit.pos);
                    o_rec.length = 32'd1;
                end
                STYPE_DMA: begin
                    o_rec_valid  = dma_bit.found;
                    o_rec.kind   = KIND_DMA;
                    o_rec.start  = 32'(dma_bit.pos);
                    o_rec.length = 32'd1;
                end
                STYPE_IO: begin
                    o_rec_valid  = (i_cap[7] != 8'h00);
                    o_rec.kind   = KIND_IO;
                    o_rec.start  = 32'(w16_at2);
                    o_rec.length = 32'(i_cap[7]);
                end
                STYPE_FIXIO: begin
                    o_rec_valid  = 1'b1;
                    o_rec.kind   = KIND_IO;
                    o_rec.start  = 32'(w16_at1[9:0]);
                    o_rec.length = 32'(i_cap[3]);
                end
                default: ;
            endcase
        end
    end

endmodule
